// File: src/tslq_pkg.sv
// shared types, constants and helper functions for the link lock and queue status unit
package tslq_pkg;

    // width of the stored queue counters, counts saturate at its all-ones value
    localparam int COUNT_WIDTH = 32;
    localparam int INPUT_COUNT_WIDTH = 64;
    localparam int REPORT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [INPUT_COUNT_WIDTH-1:0] in_count_t;
    typedef logic [REPORT_WIDTH-1:0] report_t;

    localparam in_count_t COUNT_MAX_WIDE =
        {INPUT_COUNT_WIDTH{1'b1}} >> (INPUT_COUNT_WIDTH - COUNT_WIDTH);

    // request operations
    typedef enum logic [2:0] {
        KIND_SET_STABLE    = 3'd0,
        KIND_TRY_LOCK      = 3'd1,
        KIND_UNLOCK        = 3'd2,
        KIND_CLEAR_WAITING = 3'd3,
        KIND_UPDATE_QUEUE  = 3'd4,
        KIND_READ_QUEUE    = 3'd5,
        KIND_SET_SIGNAL    = 3'd6
    } kind_t;

    // status word layout: bit index is {group, side}
    localparam int STATUS_WIDTH = 6;
    localparam logic [1:0] GRP_STABLE = 2'd0;
    localparam logic [1:0] GRP_LOCK   = 2'd1;
    localparam logic [1:0] GRP_WAIT   = 2'd2;

    typedef logic [STATUS_WIDTH-1:0] status_t;

    // transaction presented to the status word and queue bank
    typedef struct packed {
        logic       fire;
        logic [2:0] kind;
        logic       side;
    } req_t;

    function automatic count_t sat_count(input in_count_t value);
        count_t result;
        if (value >= COUNT_MAX_WIDE)
            result = '1;
        else
            result = value[COUNT_WIDTH-1:0];
        return result;
    endfunction

    function automatic report_t report_count(input count_t value);
        logic [INPUT_COUNT_WIDTH-1:0] wide;
        wide = INPUT_COUNT_WIDTH'(value);
        return wide[REPORT_WIDTH-1:0];
    endfunction

endpackage

// File: src/tslq_status_word.sv
// six-bit stable/lock/waiting status word with its atomic update rules
module tslq_status_word
    import tslq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    output logic flag
);

    status_t status_reg;
    status_t status_next;

    logic [2:0] self_stable_idx;
    logic [2:0] other_stable_idx;
    logic [2:0] self_lock_idx;
    logic [2:0] self_wait_idx;
    logic       any_lock;
    logic       both_stable;

    assign self_stable_idx  = {GRP_STABLE, req.side};
    assign other_stable_idx = {GRP_STABLE, ~req.side};
    assign self_lock_idx    = {GRP_LOCK, req.side};
    assign self_wait_idx    = {GRP_WAIT, req.side};
    assign any_lock    = status_reg[{GRP_LOCK, 1'b0}] | status_reg[{GRP_LOCK, 1'b1}];
    assign both_stable = status_reg[{GRP_STABLE, 1'b0}] & status_reg[{GRP_STABLE, 1'b1}];

    always_comb
    begin
        status_next = status_reg;
        flag = 1'b0;
        case (req.kind)
            KIND_SET_STABLE:
            begin
                status_next[self_stable_idx] = 1'b1;
            end
            KIND_TRY_LOCK:
            begin
                if (!any_lock && status_reg[self_stable_idx])
                begin
                    if (status_reg[other_stable_idx])
                    begin
                        status_next[self_lock_idx] = 1'b1;
                        flag = 1'b1;
                    end
                    else
                    begin
                        status_next[self_wait_idx] = 1'b1;
                    end
                end
            end
            KIND_UNLOCK:
            begin
                status_next[self_lock_idx] = 1'b0;
            end
            KIND_CLEAR_WAITING:
            begin
                if (both_stable && status_reg[self_wait_idx] && !any_lock)
                begin
                    status_next[self_wait_idx] = 1'b0;
                    flag = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= '0;
        else if (req.fire)
            status_reg <= status_next;
    end

    // only one side can ever hold the lock
    a_single_owner: assert property (@(posedge clk) disable iff (!rst_n)
        !(status_reg[{GRP_LOCK, 1'b0}] && status_reg[{GRP_LOCK, 1'b1}]))
        else $error("both sides hold the lock");

    // a held lock implies both sides were stable when it was taken
    a_lock_needs_stable: assert property (@(posedge clk) disable iff (!rst_n)
        any_lock |-> both_stable)
        else $error("lock held while a side is unstable");

    // stable bits are never cleared once set
    a_stable_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(status_reg[{GRP_STABLE, 1'b0}]) && !$fell(status_reg[{GRP_STABLE, 1'b1}]))
        else $error("stable bit cleared");

endmodule

// File: src/tslq_queue_bank.sv
// per-side saturating queue counters and signal-on-consume flags
module tslq_queue_bank
    import tslq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req,
    input  in_count_t byte_count,
    input  in_count_t parcel_count,
    input  logic      signal_value,
    output logic      flag,
    output report_t   bytes_queued,
    output report_t   parcels_queued
);

    count_t     byte_counts_reg [2];
    count_t     parcel_counts_reg [2];
    logic [1:0] signal_flags_reg;

    count_t byte_sel_next;
    count_t parcel_sel_next;
    logic   signal_sel_next;
    logic   is_update;
    logic   is_signal;

    assign is_update = (req.kind == KIND_UPDATE_QUEUE);
    assign is_signal = (req.kind == KIND_SET_SIGNAL);

    always_comb
    begin
        byte_sel_next   = byte_counts_reg[req.side];
        parcel_sel_next = parcel_counts_reg[req.side];
        signal_sel_next = signal_flags_reg[req.side];
        flag = 1'b0;
        if (is_update)
        begin
            byte_sel_next   = sat_count(byte_count);
            parcel_sel_next = sat_count(parcel_count);
            flag = signal_flags_reg[req.side];
        end
        if (is_signal)
        begin
            signal_sel_next = signal_value;
            flag = signal_flags_reg[req.side];
        end
    end

    // counts of the addressed side after this transaction
    assign bytes_queued   = report_count(byte_sel_next);
    assign parcels_queued = report_count(parcel_sel_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_counts_reg[0]   <= '0;
            byte_counts_reg[1]   <= '0;
            parcel_counts_reg[0] <= '0;
            parcel_counts_reg[1] <= '0;
            signal_flags_reg     <= '0;
        end
        else if (req.fire)
        begin
            byte_counts_reg[req.side]   <= byte_sel_next;
            parcel_counts_reg[req.side] <= parcel_sel_next;
            signal_flags_reg[req.side]  <= signal_sel_next;
        end
    end

    // a transaction from side b never moves the counters of side a
    a_side_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fire && req.side) |=> $stable(byte_counts_reg[0])
                                   && $stable(parcel_counts_reg[0]))
        else $error("counter of side a changed by side b");

    // a transaction from side a never moves the counters of side b
    a_side_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fire && !req.side) |=> $stable(byte_counts_reg[1])
                                    && $stable(parcel_counts_reg[1]))
        else $error("counter of side b changed by side a");

    // only set signal changes a signal flag
    a_flag_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (req.fire && !is_signal) |=> $stable(signal_flags_reg))
        else $error("signal flag changed by another operation");

    // read queue and every other operation leave the counters alone
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.fire && is_update) |=> $stable(byte_counts_reg[0])
                                     && $stable(byte_counts_reg[1]))
        else $error("byte count changed outside update");

endmodule

// File: src/two_side_link_lock_and_queue_status_unit.sv
// top level of the two-side link lock and queue status unit
//
// shared status word for two parties, side a and side b: stable, lock and
// waiting bits per side, saturating byte and parcel queue counts per side and
// a signal-on-consume flag per side
//
// request channel (req_valid/req_ready) carries one transaction: kind, side,
// byte_count, parcel_count and signal_value; response channel
// (rsp_valid/rsp_ready) returns exactly one transaction per request: flag,
// bytes_queued and parcels_queued of the addressed side after the update
//
// a request accepted into the request register is applied to the state when it
// moves into the response register, where its response turns valid
// throughput: one request per cycle without stalls, set by the read-modify-write
// of the status word and counters between the request and response registers
//
// reset (rst_n low, asynchronous) clears the status word, all counts and
// signal flags and empties both pipeline registers
// when the receiver stalls, the response register holds its transaction, the
// request register fills and then req_ready drops; nothing is lost or repeated
module two_side_link_lock_and_queue_status_unit
    import tslq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  logic [2:0] kind,
    input  logic      side,
    input  in_count_t byte_count,
    input  in_count_t parcel_count,
    input  logic      signal_value,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output logic      flag,
    output report_t   bytes_queued,
    output report_t   parcels_queued
);

    // request register
    logic       req_valid_reg;
    logic [2:0] kind_reg;
    logic       side_reg;
    in_count_t  byte_count_reg;
    in_count_t  parcel_count_reg;
    logic       signal_value_reg;

    // response register
    logic    rsp_valid_reg;
    logic    flag_reg;
    report_t bytes_queued_reg;
    report_t parcels_queued_reg;

    logic    advance;
    req_t    req;
    logic    status_flag;
    logic    queue_flag;
    logic    flag_next;
    report_t bytes_next;
    report_t parcels_next;

    // the request register moves into the response register when that one is
    // empty or is being taken this cycle
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;

    assign req.fire = advance;
    assign req.kind = kind_reg;
    assign req.side = side_reg;

    tslq_status_word u_status (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .flag  (status_flag)
    );

    tslq_queue_bank u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .byte_count     (byte_count_reg),
        .parcel_count   (parcel_count_reg),
        .signal_value   (signal_value_reg),
        .flag           (queue_flag),
        .bytes_queued   (bytes_next),
        .parcels_queued (parcels_next)
    );

    // each unit drives its flag only for its own operations, zero otherwise
    assign flag_next = status_flag | queue_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                req_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            kind_reg         <= kind;
            side_reg         <= side;
            byte_count_reg   <= byte_count;
            parcel_count_reg <= parcel_count;
            signal_value_reg <= signal_value;
        end
        if (advance)
        begin
            flag_reg           <= flag_next;
            bytes_queued_reg   <= bytes_next;
            parcels_queued_reg <= parcels_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign flag           = flag_reg;
    assign bytes_queued   = bytes_queued_reg;
    assign parcels_queued = parcels_queued_reg;

    // every processed request produces a response in the next cycle
    a_advance_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("processed request produced no response");

    // set stable, unlock and read queue always report a clear flag
    a_plain_kinds_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg == KIND_SET_STABLE || kind_reg == KIND_UNLOCK
                     || kind_reg == KIND_READ_QUEUE)) |=> !flag_reg)
        else $error("flag set for an operation that reports none");

    // a stalled response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |-> !advance)
        else $error("response overwritten while stalled");

endmodule

// File: tb/link_status_checker.sv
// transaction checker and status word predictor for the link lock and queue status unit
`timescale 1ns / 1ps

module link_status_checker
    import tslq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  logic [2:0] kind,
    input  logic       side,
    input  in_count_t  byte_count,
    input  in_count_t  parcel_count,
    input  logic       signal_value,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  logic       flag,
    input  report_t    bytes_queued,
    input  report_t    parcels_queued,
    output int         mismatches,
    output int         replies_outstanding
);

    typedef struct {
        logic    flag;
        report_t bytes;
        report_t parcels;
    } link_reply_t;

    link_reply_t replies_due[$];

    // predicted copy of the block state
    status_t link_bits;
    count_t  bytes_held [2];
    count_t  parcels_held [2];
    logic    signal_held [2];

    function automatic count_t clip_count(input in_count_t value);
        count_t clipped;
        if (value[INPUT_COUNT_WIDTH-1:COUNT_WIDTH] != '0)
            clipped = '1;
        else
            clipped = value[COUNT_WIDTH-1:0];
        return clipped;
    endfunction

    // applies one request to the predicted state and returns its reply
    function automatic link_reply_t apply_request(input logic [2:0] op, input logic s,
                                                  input in_count_t bytes_in,
                                                  input in_count_t parcels_in,
                                                  input logic signal_in);
        link_reply_t reply;
        status_t     st;
        logic        any_lock;
        logic        both_stable;
        st          = link_bits;
        reply.flag  = 1'b0;
        any_lock    = st[{GRP_LOCK, 1'b0}] | st[{GRP_LOCK, 1'b1}];
        both_stable = st[{GRP_STABLE, 1'b0}] & st[{GRP_STABLE, 1'b1}];
        case (op)
            KIND_SET_STABLE:
                st[{GRP_STABLE, s}] = 1'b1;
            KIND_TRY_LOCK:
                if (!any_lock && st[{GRP_STABLE, s}]) begin
                    if (st[{GRP_STABLE, ~s}]) begin
                        st[{GRP_LOCK, s}] = 1'b1;
                        reply.flag = 1'b1;
                    end
                    else begin
                        st[{GRP_WAIT, s}] = 1'b1;
                    end
                end
            KIND_UNLOCK:
                st[{GRP_LOCK, s}] = 1'b0;
            KIND_CLEAR_WAITING:
                if (both_stable && st[{GRP_WAIT, s}] && !any_lock) begin
                    st[{GRP_WAIT, s}] = 1'b0;
                    reply.flag = 1'b1;
                end
            KIND_UPDATE_QUEUE: begin
                bytes_held[s]   = clip_count(bytes_in);
                parcels_held[s] = clip_count(parcels_in);
                reply.flag      = signal_held[s];
            end
            KIND_SET_SIGNAL: begin
                reply.flag     = signal_held[s];
                signal_held[s] = signal_in;
            end
            default: ;
        endcase
        link_bits     = st;
        reply.bytes   = report_t'(bytes_held[s]);
        reply.parcels = report_t'(parcels_held[s]);
        return reply;
    endfunction

    assign replies_outstanding = replies_due.size();

    initial begin
        mismatches = 0;
    end

    always @(posedge clk) begin
        link_reply_t want;
        if (!rst_n) begin
            for (int i = 0; i < 2; i++) begin
                bytes_held[i]   = '0;
                parcels_held[i] = '0;
                signal_held[i]  = 1'b0;
            end
            link_bits = '0;
            replies_due.delete();
        end
        else begin
            // response side first, a request never answers in its own cycle
            if (rsp_valid && rsp_ready) begin
                if (replies_due.size() == 0) begin
                    $error("response transaction with nothing expected");
                    mismatches++;
                end
                else begin
                    want = replies_due.pop_front();
                    if (flag !== want.flag) begin
                        $error("flag: expected %0d, got %0d", want.flag, flag);
                        mismatches++;
                    end
                    if (bytes_queued !== want.bytes) begin
                        $error("bytes_queued: expected %0d, got %0d", want.bytes,
                               bytes_queued);
                        mismatches++;
                    end
                    if (parcels_queued !== want.parcels) begin
                        $error("parcels_queued: expected %0d, got %0d", want.parcels,
                               parcels_queued);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
                replies_due.push_back(apply_request(kind, side, byte_count, parcel_count,
                                                    signal_value));
        end
    end

endmodule

// File: tb/two_side_link_lock_and_queue_status_unit_tb.sv
// stimulus and verdict for the two-side link lock and queue status unit
`timescale 1ns / 1ps

module two_side_link_lock_and_queue_status_unit_tb
    import tslq_pkg::*;
();

    // kind seven has no operation, the block must leave the state alone
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    // hard stop limit, set well above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int MAX_WAIT = 17;
    // margin after the last reply is taken
    localparam int DRAIN_CYCLES = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [2:0] kind = KIND_SET_STABLE;
    logic       side = 1'b0;
    in_count_t  byte_count = '0;
    in_count_t  parcel_count = '0;
    logic       signal_value = 1'b0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    logic       flag;
    report_t    bytes_queued;
    report_t    parcels_queued;

    int mismatches;
    int replies_outstanding;
    int cycle_count = 0;

    // remaining length of a stretch with no idling, one per side
    int send_calm = 0;
    int take_calm = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    two_side_link_lock_and_queue_status_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .kind           (kind),
        .side           (side),
        .byte_count     (byte_count),
        .parcel_count   (parcel_count),
        .signal_value   (signal_value),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .flag           (flag),
        .bytes_queued   (bytes_queued),
        .parcels_queued (parcels_queued)
    );

    // watches both channels, predicts every reply and counts mismatches
    link_status_checker status_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_ready           (req_ready),
        .kind                (kind),
        .side                (side),
        .byte_count          (byte_count),
        .parcel_count        (parcel_count),
        .signal_value        (signal_value),
        .rsp_valid           (rsp_valid),
        .rsp_ready           (rsp_ready),
        .flag                (flag),
        .bytes_queued        (bytes_queued),
        .parcels_queued      (parcels_queued),
        .mismatches          (mismatches),
        .replies_outstanding (replies_outstanding)
    );

    // hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("two_side_link_lock_and_queue_status_unit_tb failed");
            $finish;
        end
    end

    // idle cycles before the next transaction: mostly random, sometimes a stretch of none
    function automatic int draw_wait(inout int calm_left);
        int cycles;
        if (calm_left > 0) begin
            calm_left--;
            cycles = 0;
        end
        else if ($urandom_range(0, 11) == 0) begin
            calm_left = $urandom_range(10, 40);
            cycles = 0;
        end
        else begin
            cycles = $urandom_range(0, MAX_WAIT);
        end
        return cycles;
    endfunction

    // counts clustered around the saturation edge, plus small and fully random ones
    function automatic in_count_t pick_count();
        in_count_t value;
        case ($urandom_range(0, 5))
            0: value = in_count_t'($urandom_range(0, 1000));
            1: value = 64'h0000_0000_FFFF_FFFF + in_count_t'($urandom_range(0, 4)) - 64'd2;
            2: value = {32'h0, $urandom};
            3: value = '1;
            default: value = {$urandom, $urandom};
        endcase
        return value;
    endfunction

    // offers one request transaction and returns at the edge that accepts it;
    // with no idle cycle the next payload follows in the same step, valid stays high
    task automatic send_request(input logic [2:0] op, input logic s, input in_count_t bytes_in,
                                input in_count_t parcels_in, input logic signal_in);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        kind         <= op;
        side         <= s;
        byte_count   <= bytes_in;
        parcel_count <= parcels_in;
        signal_value <= signal_in;
        do @(posedge clk); while (!req_ready);
    endtask

    // response side: random stall before each transaction, ready held until it is taken
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        logic [2:0] op;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lock protocol from cold start, with every refusal path
        send_request(KIND_READ_QUEUE, 1'b0, '0, '0, 1'b0);
        send_request(KIND_TRY_LOCK, 1'b0, '1, '1, 1'b1);        // requester unstable
        send_request(KIND_CLEAR_WAITING, 1'b0, '0, '0, 1'b0);   // link not stable
        send_request(KIND_UNLOCK, 1'b1, '0, '0, 1'b0);          // unlock with no lock held
        send_request(KIND_SET_STABLE, 1'b0, '0, '0, 1'b0);
        send_request(KIND_TRY_LOCK, 1'b0, '0, '0, 1'b0);        // only a stable, sets waiting
        send_request(KIND_CLEAR_WAITING, 1'b0, '0, '0, 1'b0);   // b still unstable
        send_request(KIND_CLEAR_WAITING, 1'b1, '0, '0, 1'b0);   // b not waiting
        send_request(KIND_SET_STABLE, 1'b1, '0, '0, 1'b0);
        send_request(KIND_CLEAR_WAITING, 1'b0, '0, '0, 1'b0);   // a waiting cleared
        send_request(KIND_TRY_LOCK, 1'b0, '0, '0, 1'b0);        // a wins
        send_request(KIND_TRY_LOCK, 1'b1, '0, '0, 1'b0);        // already locked
        send_request(KIND_UNLOCK, 1'b1, '0, '0, 1'b0);          // b does not hold it
        send_request(KIND_UNLOCK, 1'b0, '0, '0, 1'b0);
        send_request(KIND_TRY_LOCK, 1'b1, '0, '0, 1'b0);        // b wins
        send_request(KIND_UNLOCK, 1'b1, '0, '0, 1'b0);

        // directed: saturation edges and signal flags
        send_request(KIND_UPDATE_QUEUE, 1'b0, '1, '1, 1'b0);
        send_request(KIND_UPDATE_QUEUE, 1'b1, 64'h0000_0000_FFFF_FFFF,
                     64'h0000_0000_FFFF_FFFE, 1'b0);
        send_request(KIND_UPDATE_QUEUE, 1'b0, 64'h0000_0001_0000_0000, '0, 1'b0);
        send_request(KIND_SET_SIGNAL, 1'b0, '0, '0, 1'b1);
        send_request(KIND_UPDATE_QUEUE, 1'b0, 64'd5, 64'd7, 1'b0);   // flag now set
        send_request(KIND_SET_SIGNAL, 1'b1, '0, '0, 1'b1);
        send_request(KIND_SET_SIGNAL, 1'b0, '0, '0, 1'b0);           // returns old flag
        send_request(KIND_UNUSED, 1'b1, '1, '1, 1'b1);
        send_request(KIND_READ_QUEUE, 1'b1, '0, '0, 1'b0);

        // random: every kind, weighted toward lock and unlock contention
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(0, 15))
                0, 1:    op = KIND_SET_STABLE;
                2, 3, 4: op = KIND_TRY_LOCK;
                5, 6, 7: op = KIND_UNLOCK;
                8, 9:    op = KIND_CLEAR_WAITING;
                10, 11:  op = KIND_UPDATE_QUEUE;
                12:      op = KIND_READ_QUEUE;
                13, 14:  op = KIND_SET_SIGNAL;
                default: op = KIND_UNUSED;
            endcase
            send_request(op, 1'($urandom_range(0, 1)), pick_count(), pick_count(),
                         1'($urandom_range(0, 1)));
        end
        req_valid <= 1'b0;

        // let the checker record the last transaction, then drain every reply;
        // the cycle limit guards a hang
        @(posedge clk);
        while (replies_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("two_side_link_lock_and_queue_status_unit_tb passed");
        else
            $display("two_side_link_lock_and_queue_status_unit_tb failed");
        $finish;
    end

endmodule
